// ===== design/mismatch_mask_feature_extractor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Mismatch mask feature extractor - assertion macros
// Concurrent assertion helpers used by the extractor design file.
// ----------------------------------------------------------------------------
`ifndef MISMATCH_MASK_FEATURE_EXTRACTOR_UNIT_ASSERT_SVH
`define MISMATCH_MASK_FEATURE_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MMFE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MMFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Mismatch mask feature extractor - package
// Field widths, status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mmfe_pkg;

	// Field widths
	localparam int MASK_W    = 64;
	localparam int LEN_W     = 7;
	localparam int CNT_W     = 7;
	localparam int CFG_W     = 7;
	localparam int STATUS_W  = 3;
	localparam int OFFSET_W  = 6;
	localparam int REG_IDX_W = 3;

	// Popcount / search group size
	localparam int GROUP_W = 8;

	localparam int DEFAULT_MAX_BASES = 64;

	// Result status codes, in check order
	typedef enum logic [STATUS_W-1:0] {
		ST_OK             = 3'd0,
		ST_BAD_LENGTH     = 3'd1,
		ST_STRAY_BITS     = 3'd2,
		ST_BAD_ANCHOR     = 3'd3,
		ST_COUNT_MISMATCH = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FIVE_PRIME_WINDOW        = 3'd0,
		REG_THREE_PRIME_WINDOW_LONG  = 3'd1,
		REG_THREE_PRIME_WINDOW_MID   = 3'd2,
		REG_THREE_PRIME_WINDOW_SHORT = 3'd3,
		REG_ANCHOR_WIDTH             = 3'd4
	} reg_index_t;

	// Register reset values
	localparam logic [CFG_W-1:0] FIVE_PRIME_WINDOW_RST        = 7'd5;
	localparam logic [CFG_W-1:0] THREE_PRIME_WINDOW_LONG_RST  = 7'd8;
	localparam logic [CFG_W-1:0] THREE_PRIME_WINDOW_MID_RST   = 7'd5;
	localparam logic [CFG_W-1:0] THREE_PRIME_WINDOW_SHORT_RST = 7'd3;
	localparam logic [CFG_W-1:0] ANCHOR_WIDTH_RST             = 7'd3;

endpackage

// ===== design/mmfe_in_if.sv =====
// ----------------------------------------------------------------------------
// Mismatch mask feature extractor - input channel
// Valid/ready channel carrying one primer mask, its length and claimed count.
// ----------------------------------------------------------------------------
interface mmfe_in_if;
	logic                         valid;
	logic                         ready;
	logic [mmfe_pkg::MASK_W-1:0]  mask;
	logic [mmfe_pkg::LEN_W-1:0]   length;
	logic [mmfe_pkg::CNT_W-1:0]   reported_count;

	modport source (output valid, output mask, output length, output reported_count,
		input ready);
	modport sink (input valid, input mask, input length, input reported_count,
		output ready);
endinterface

// ===== design/mmfe_out_if.sv =====
// ----------------------------------------------------------------------------
// Mismatch mask feature extractor - result channel
// Valid/ready channel carrying the status and features of one primer.
// ----------------------------------------------------------------------------
interface mmfe_out_if;
	logic                           valid;
	logic                           ready;
	logic [mmfe_pkg::STATUS_W-1:0]  status;
	logic [mmfe_pkg::CNT_W-1:0]     total_count;
	logic [mmfe_pkg::CNT_W-1:0]     head_count;
	logic [mmfe_pkg::CNT_W-1:0]     tail_long_count;
	logic [mmfe_pkg::CNT_W-1:0]     tail_mid_count;
	logic [mmfe_pkg::CNT_W-1:0]     tail_short_count;
	logic                           terminal_mismatch;
	logic                           anchor_overlap;
	logic                           any_mismatch;
	logic [mmfe_pkg::OFFSET_W-1:0]  nearest_offset;

	modport source (output valid, output status, output total_count, output head_count,
		output tail_long_count, output tail_mid_count, output tail_short_count,
		output terminal_mismatch, output anchor_overlap, output any_mismatch,
		output nearest_offset, input ready);
	modport sink (input valid, input status, input total_count, input head_count,
		input tail_long_count, input tail_mid_count, input tail_short_count,
		input terminal_mismatch, input anchor_overlap, input any_mismatch,
		input nearest_offset, output ready);
endinterface

// ===== design/mismatch_mask_feature_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// Mismatch mask feature extractor
// Checks a primer mismatch mask and extracts window popcounts, 3-prime end
// flags and the offset of the nearest mismatch from the 3-prime end.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    mask, length, reported_count
//  out_ch    out  valid/ready    status, counts, flags, nearest_offset
//  wr_*      in   wr_en only     wr_index, wr_data (5 registers, no read-back)
//
//  A result passes through stages s1 to s4 and then goes valid on out_ch; one
//  transaction per cycle is sustained while out_ch is ready.
//  The four stages are: checks and window masks,
//  8-bit group popcounts and group priority search, group sums and merge,
//  final status and output register. Each stage advances when it is empty or
//  the one after it advances, so a stall on out_ch backs up without loss.
//  arst_n clears the stage valid bits and loads the register reset values.
//
module mismatch_mask_feature_extractor_unit #(
	parameter int MAX_BASES = mmfe_pkg::DEFAULT_MAX_BASES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mmfe_in_if.sink                         in_ch,
	mmfe_out_if.source                      out_ch,
	input  logic                            wr_en,
	input  logic [mmfe_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [mmfe_pkg::CFG_W-1:0]      wr_data
);

`include "mismatch_mask_feature_extractor_unit_assert.svh"

	localparam int NG      = (MAX_BASES + mmfe_pkg::GROUP_W - 1) / mmfe_pkg::GROUP_W;
	localparam int PAD_W   = NG * mmfe_pkg::GROUP_W;
	localparam int PCNT_W  = $clog2(mmfe_pkg::GROUP_W + 1);
	localparam int GTOP_W  = $clog2(mmfe_pkg::GROUP_W);
	localparam int LEN_W   = mmfe_pkg::LEN_W;
	localparam int CNT_W   = mmfe_pkg::CNT_W;
	localparam int OFF_W   = mmfe_pkg::OFFSET_W;

	// Stage payloads
	typedef struct packed {
		logic [MAX_BASES-1:0] mask;
		logic [MAX_BASES-1:0] head_bits;
		logic [MAX_BASES-1:0] long_bits;
		logic [MAX_BASES-1:0] mid_bits;
		logic [MAX_BASES-1:0] short_bits;
		logic [MAX_BASES-1:0] anchor_bits;
		logic                 terminal;
		logic [LEN_W-1:0]     len;
		logic [CNT_W-1:0]     reported;
		mmfe_pkg::status_t    status;
	} st1_t;

	typedef struct packed {
		logic [NG-1:0][PCNT_W-1:0] tot_p;
		logic [NG-1:0][PCNT_W-1:0] head_p;
		logic [NG-1:0][PCNT_W-1:0] long_p;
		logic [NG-1:0][PCNT_W-1:0] mid_p;
		logic [NG-1:0][PCNT_W-1:0] short_p;
		logic [NG-1:0]             grp_nz;
		logic [NG-1:0][GTOP_W-1:0] grp_top;
		logic                      anchor_hit;
		logic                      terminal;
		logic [LEN_W-1:0]          len;
		logic [CNT_W-1:0]          reported;
		mmfe_pkg::status_t         status;
	} st2_t;

	typedef struct packed {
		logic [CNT_W-1:0]  tot;
		logic [CNT_W-1:0]  head;
		logic [CNT_W-1:0]  tail_long;
		logic [CNT_W-1:0]  tail_mid;
		logic [CNT_W-1:0]  tail_short;
		logic              anchor_hit;
		logic              terminal;
		logic              any;
		logic [OFF_W-1:0]  top;
		logic [LEN_W-1:0]  len;
		logic [CNT_W-1:0]  reported;
		mmfe_pkg::status_t status;
	} st3_t;

	typedef struct packed {
		mmfe_pkg::status_t status;
		logic [CNT_W-1:0]  total_count;
		logic [CNT_W-1:0]  head_count;
		logic [CNT_W-1:0]  tail_long_count;
		logic [CNT_W-1:0]  tail_mid_count;
		logic [CNT_W-1:0]  tail_short_count;
		logic              terminal_mismatch;
		logic              anchor_overlap;
		logic              any_mismatch;
		logic [OFF_W-1:0]  nearest_offset;
	} res_t;

	// Base idx lies in the last w bases of a primer of length len
	function automatic logic in_tail(input int idx, input logic [LEN_W-1:0] w,
		input logic [LEN_W-1:0] len);
		logic [LEN_W:0] lhs;
		lhs = {1'b0, LEN_W'(idx)} + {1'b0, w};
		return ({1'b0, LEN_W'(idx)} < {1'b0, len}) && (lhs >= {1'b0, len});
	endfunction

	function automatic logic [PCNT_W-1:0] pop_group(input logic [mmfe_pkg::GROUP_W-1:0] v);
		logic [PCNT_W-1:0] c;
		c = '0;
		for (int b = 0; b < mmfe_pkg::GROUP_W; b++) c = c + PCNT_W'(v[b]);
		return c;
	endfunction

	function automatic logic [GTOP_W-1:0] top_group(input logic [mmfe_pkg::GROUP_W-1:0] v);
		logic [GTOP_W-1:0] t;
		t = '0;
		for (int b = 0; b < mmfe_pkg::GROUP_W; b++) if (v[b]) t = GTOP_W'(b);
		return t;
	endfunction

	function automatic logic [CNT_W-1:0] sum_parts(input logic [NG-1:0][PCNT_W-1:0] p);
		logic [CNT_W-1:0] s;
		s = '0;
		for (int g = 0; g < NG; g++) s = s + CNT_W'(p[g]);
		return s;
	endfunction

	// Configuration registers
	logic [mmfe_pkg::CFG_W-1:0] five_win_q, long_win_q, mid_win_q, short_win_q, anchor_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			five_win_q  <= mmfe_pkg::FIVE_PRIME_WINDOW_RST;
			long_win_q  <= mmfe_pkg::THREE_PRIME_WINDOW_LONG_RST;
			mid_win_q   <= mmfe_pkg::THREE_PRIME_WINDOW_MID_RST;
			short_win_q <= mmfe_pkg::THREE_PRIME_WINDOW_SHORT_RST;
			anchor_w_q  <= mmfe_pkg::ANCHOR_WIDTH_RST;
		end else if (wr_en) begin
			unique case (mmfe_pkg::reg_index_t'(wr_index))
				mmfe_pkg::REG_FIVE_PRIME_WINDOW:        five_win_q  <= wr_data;
				mmfe_pkg::REG_THREE_PRIME_WINDOW_LONG:  long_win_q  <= wr_data;
				mmfe_pkg::REG_THREE_PRIME_WINDOW_MID:   mid_win_q   <= wr_data;
				mmfe_pkg::REG_THREE_PRIME_WINDOW_SHORT: short_win_q <= wr_data;
				mmfe_pkg::REG_ANCHOR_WIDTH:             anchor_w_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage loads when empty or when its successor loads
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4 = !v_s4 || out_ch.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: input checks and window masks
	st1_t nxt1, st_s1;
	logic stray;

	always_comb begin
		stray = 1'b0;
		for (int i = 0; i < mmfe_pkg::MASK_W; i++) begin
			if (in_ch.mask[i] && (LEN_W'(i) >= in_ch.length)) stray = 1'b1;
		end
		nxt1.mask        = in_ch.mask[MAX_BASES-1:0];
		nxt1.terminal    = 1'b0;
		nxt1.head_bits   = '0;
		nxt1.long_bits   = '0;
		nxt1.mid_bits    = '0;
		nxt1.short_bits  = '0;
		nxt1.anchor_bits = '0;
		for (int i = 0; i < MAX_BASES; i++) begin
			nxt1.head_bits[i]   = in_ch.mask[i] && (LEN_W'(i) < five_win_q)
				&& (LEN_W'(i) < in_ch.length);
			nxt1.long_bits[i]   = in_ch.mask[i] && in_tail(i, long_win_q, in_ch.length);
			nxt1.mid_bits[i]    = in_ch.mask[i] && in_tail(i, mid_win_q, in_ch.length);
			nxt1.short_bits[i]  = in_ch.mask[i] && in_tail(i, short_win_q, in_ch.length);
			nxt1.anchor_bits[i] = in_ch.mask[i] && in_tail(i, anchor_w_q, in_ch.length);
			if (in_ch.mask[i] && (LEN_W'(i) == in_ch.length - LEN_W'(1))) nxt1.terminal = 1'b1;
		end
		nxt1.len      = in_ch.length;
		nxt1.reported = in_ch.reported_count;
		if ((in_ch.length == '0) || (in_ch.length > LEN_W'(MAX_BASES)))
			nxt1.status = mmfe_pkg::ST_BAD_LENGTH;
		else if (stray)
			nxt1.status = mmfe_pkg::ST_STRAY_BITS;
		else if ((anchor_w_q == '0) || (anchor_w_q > in_ch.length))
			nxt1.status = mmfe_pkg::ST_BAD_ANCHOR;
		else
			nxt1.status = mmfe_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) st_s1 <= nxt1;
	end

	// Stage 2: per-group popcounts and highest set bit per group
	st2_t nxt2, st_s2;
	logic [PAD_W-1:0] pm, ph, pl, pmid, ps;

	always_comb begin
		pm   = PAD_W'(st_s1.mask);
		ph   = PAD_W'(st_s1.head_bits);
		pl   = PAD_W'(st_s1.long_bits);
		pmid = PAD_W'(st_s1.mid_bits);
		ps   = PAD_W'(st_s1.short_bits);
		for (int g = 0; g < NG; g++) begin
			nxt2.tot_p[g]   = pop_group(pm[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
			nxt2.head_p[g]  = pop_group(ph[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
			nxt2.long_p[g]  = pop_group(pl[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
			nxt2.mid_p[g]   = pop_group(pmid[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
			nxt2.short_p[g] = pop_group(ps[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
			nxt2.grp_nz[g]  = |pm[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W];
			nxt2.grp_top[g] = top_group(pm[g*mmfe_pkg::GROUP_W +: mmfe_pkg::GROUP_W]);
		end
		nxt2.anchor_hit = |st_s1.anchor_bits;
		nxt2.terminal   = st_s1.terminal;
		nxt2.len        = st_s1.len;
		nxt2.reported   = st_s1.reported;
		nxt2.status     = st_s1.status;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) st_s2 <= nxt2;
	end

	// Stage 3: sum group counts, merge group search
	st3_t nxt3, st_s3;

	always_comb begin
		nxt3.tot        = sum_parts(st_s2.tot_p);
		nxt3.head       = sum_parts(st_s2.head_p);
		nxt3.tail_long  = sum_parts(st_s2.long_p);
		nxt3.tail_mid   = sum_parts(st_s2.mid_p);
		nxt3.tail_short = sum_parts(st_s2.short_p);
		nxt3.any        = |st_s2.grp_nz;
		nxt3.top        = '0;
		for (int g = 0; g < NG; g++) begin
			if (st_s2.grp_nz[g])
				nxt3.top = OFF_W'(g * mmfe_pkg::GROUP_W + int'(st_s2.grp_top[g]));
		end
		nxt3.anchor_hit = st_s2.anchor_hit;
		nxt3.terminal   = st_s2.terminal;
		nxt3.len        = st_s2.len;
		nxt3.reported   = st_s2.reported;
		nxt3.status     = st_s2.status;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) st_s3 <= nxt3;
	end

	// Stage 4: count check, zeroing on error, output register
	res_t nxt4, res_s4;
	mmfe_pkg::status_t fin_status;
	logic [LEN_W-1:0] end_gap;

	always_comb begin
		if ((st_s3.status == mmfe_pkg::ST_OK) && (st_s3.tot != st_s3.reported))
			fin_status = mmfe_pkg::ST_COUNT_MISMATCH;
		else
			fin_status = st_s3.status;
		end_gap = st_s3.len - LEN_W'(1) - {1'b0, st_s3.top};
		nxt4 = '0;
		nxt4.status = fin_status;
		if (fin_status == mmfe_pkg::ST_OK) begin
			nxt4.total_count       = st_s3.tot;
			nxt4.head_count        = st_s3.head;
			nxt4.tail_long_count   = st_s3.tail_long;
			nxt4.tail_mid_count    = st_s3.tail_mid;
			nxt4.tail_short_count  = st_s3.tail_short;
			nxt4.terminal_mismatch = st_s3.terminal;
			nxt4.anchor_overlap    = st_s3.anchor_hit;
			nxt4.any_mismatch      = st_s3.any;
			nxt4.nearest_offset    = st_s3.any ? end_gap[OFF_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) res_s4 <= nxt4;
	end

	// Result channel
	assign out_ch.valid             = v_s4;
	assign out_ch.status            = mmfe_pkg::STATUS_W'(res_s4.status);
	assign out_ch.total_count       = res_s4.total_count;
	assign out_ch.head_count        = res_s4.head_count;
	assign out_ch.tail_long_count   = res_s4.tail_long_count;
	assign out_ch.tail_mid_count    = res_s4.tail_mid_count;
	assign out_ch.tail_short_count  = res_s4.tail_short_count;
	assign out_ch.terminal_mismatch = res_s4.terminal_mismatch;
	assign out_ch.anchor_overlap    = res_s4.anchor_overlap;
	assign out_ch.any_mismatch      = res_s4.any_mismatch;
	assign out_ch.nearest_offset    = res_s4.nearest_offset;

	// Assertions
	`MMFE_ASSERT_IMPLIES(a_err_zeroes, clk, arst_n,
		v_s4 && (res_s4.status != mmfe_pkg::ST_OK),
		(res_s4.total_count == '0) && (res_s4.head_count == '0) && !res_s4.any_mismatch
		&& (res_s4.nearest_offset == '0) && !res_s4.anchor_overlap,
		"error result carries nonzero features")
	`MMFE_ASSERT_IMPLIES(a_any_matches_total, clk, arst_n,
		v_s4 && (res_s4.status == mmfe_pkg::ST_OK),
		res_s4.any_mismatch == (res_s4.total_count != '0),
		"any_mismatch disagrees with total_count")
	`MMFE_ASSERT_NEXT(a_s3_to_output, clk, arst_n, v_s3 && rdy_s4, v_s4,
		"stage 3 transaction lost on the way to the output register")

endmodule
